>>> rtl/core/khms_pkg.sv
// Shared types, register codes and the merge node functions for the k-way head minimum select.
package khms_pkg;

   // Fixed field widths of the command and result words.
   localparam int MAX_STREAMS = 8;
   localparam int KEY_W       = 64;
   localparam int STREAM_W    = 3;
   localparam int COUNT_W     = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int TRUTH_WORDS = 4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_TABLES = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRUTH_0    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRUTH_1    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRUTH_2    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TRUTH_3    = 3'd4;

   // Command word: valid mask and the head key of each stream.
   typedef struct packed {
      logic [MAX_STREAMS-1:0] head_valid;
      logic [KEY_W-1:0]       key_0;
      logic [KEY_W-1:0]       key_1;
      logic [KEY_W-1:0]       key_2;
      logic [KEY_W-1:0]       key_3;
      logic [KEY_W-1:0]       key_4;
      logic [KEY_W-1:0]       key_5;
      logic [KEY_W-1:0]       key_6;
      logic [KEY_W-1:0]       key_7;
   } req_type;

   // Result word.
   typedef struct packed {
      logic                   any_live;
      logic [MAX_STREAMS-1:0] presence_mask;
      logic [STREAM_W-1:0]    first_stream;
      logic                   keep_key;
   } rsp_type;

   // Control part of a partial minimum over a group of streams.
   typedef struct packed {
      logic                   live;
      logic [MAX_STREAMS-1:0] mask;
      logic [STREAM_W-1:0]    first;
   } node_ctl_type;

   // True when the lower group a supplies the minimum key.
   function automatic logic pick_lower(input node_ctl_type a, input node_ctl_type b,
                                       input logic a_lt, input logic a_eq);
      return a.live && (!b.live || a_lt || a_eq);
   endfunction

   // Combine two groups; a holds the lower stream indexes, so it wins ties.
   function automatic node_ctl_type merge_ctl(input node_ctl_type a, input node_ctl_type b,
                                              input logic a_lt, input logic a_eq);
      node_ctl_type r;
      r = b;
      if (a.live && (!b.live || a_lt)) begin
         r = a;
      end else if (a.live && a_eq) begin
         r = a;
         r.mask = a.mask | b.mask;
      end
      return r;
   endfunction

endpackage

>>> rtl/core/khms_lane_pair.sv
// One compare lane: qualifies two streams and registers the smaller of their keys.
module khms_lane_pair #(
   parameter int KEY_BITS = 64,
   parameter int LANE     = 0
) (
   input  logic                          clock,
   input  logic [1:0]                    valid_pair,
   input  logic [khms_pkg::KEY_W-1:0]    key_lo,
   input  logic [khms_pkg::KEY_W-1:0]    key_hi,
   input  logic [khms_pkg::COUNT_W-1:0]  used_count,
   output khms_pkg::node_ctl_type        node_ctl,
   output logic [KEY_BITS-1:0]           node_key
);
   import khms_pkg::*;

   localparam logic [COUNT_W-1:0] IDX_LO = COUNT_W'(2 * LANE);
   localparam logic [COUNT_W-1:0] IDX_HI = COUNT_W'(2 * LANE + 1);

   logic [KEY_BITS-1:0] klo;
   logic [KEY_BITS-1:0] khi;
   logic                live_lo;
   logic                live_hi;
   node_ctl_type        ctl_lo;
   node_ctl_type        ctl_hi;
   logic                lo_lt;
   logic                lo_eq;
   node_ctl_type        ctl_ff;
   node_ctl_type        ctl_in;
   logic [KEY_BITS-1:0] key_ff;
   logic [KEY_BITS-1:0] key_in;

   // Keys are trimmed to the configured width; a stream is live when valid and in use.
   always_comb begin
      klo     = key_lo[KEY_BITS-1:0];
      khi     = key_hi[KEY_BITS-1:0];
      live_lo = valid_pair[0] && (IDX_LO < used_count);
      live_hi = valid_pair[1] && (IDX_HI < used_count);
      ctl_lo.live  = live_lo;
      ctl_lo.mask  = MAX_STREAMS'(live_lo) << IDX_LO;
      ctl_lo.first = live_lo ? IDX_LO[STREAM_W-1:0] : '0;
      ctl_hi.live  = live_hi;
      ctl_hi.mask  = MAX_STREAMS'(live_hi) << IDX_HI;
      ctl_hi.first = live_hi ? IDX_HI[STREAM_W-1:0] : '0;
      lo_lt = klo < khi;
      lo_eq = klo == khi;
   end

   // First level of the minimum tree.
   always_comb begin
      ctl_in = merge_ctl(ctl_lo, ctl_hi, lo_lt, lo_eq);
      key_in = pick_lower(ctl_lo, ctl_hi, lo_lt, lo_eq) ? klo : khi;
   end

   always_ff @(posedge clock) begin
      ctl_ff <= ctl_in;
      key_ff <= key_in;
   end

   assign node_ctl = ctl_ff;
   assign node_key = key_ff;

endmodule

>>> rtl/core/khms_merge.sv
// Merging stages: combines the four lane minima and looks up the keep bit.
module khms_merge #(
   parameter int KEY_BITS = 64
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         in_valid,
   input  khms_pkg::node_ctl_type [3:0]                 lane_ctl,
   input  logic [3:0][KEY_BITS-1:0]                     lane_key,
   input  logic [khms_pkg::TRUTH_WORDS-1:0][khms_pkg::KEY_W-1:0] truth,
   output logic                                         rsp_valid,
   output khms_pkg::rsp_type                            rsp_word
);
   import khms_pkg::*;

   logic                           mid_valid_ff;
   node_ctl_type [1:0]             mid_ctl_ff;
   node_ctl_type [1:0]             mid_ctl_in;
   logic [1:0][KEY_BITS-1:0]       mid_key_ff;
   logic [1:0][KEY_BITS-1:0]       mid_key_in;
   logic [1:0]                     pair_lt;
   logic [1:0]                     pair_eq;
   logic                           fin_lt;
   logic                           fin_eq;
   node_ctl_type                   fin_ctl;
   logic                           out_valid_ff;
   rsp_type                        rsp_ff;
   rsp_type                        rsp_in;

   // Second tree level: two nodes over lane pairs.
   always_comb begin
      for (int n = 0; n < 2; n++) begin
         pair_lt[n] = lane_key[2*n] < lane_key[2*n+1];
         pair_eq[n] = lane_key[2*n] == lane_key[2*n+1];
         mid_ctl_in[n] = merge_ctl(lane_ctl[2*n], lane_ctl[2*n+1], pair_lt[n], pair_eq[n]);
         mid_key_in[n] = pick_lower(lane_ctl[2*n], lane_ctl[2*n+1], pair_lt[n], pair_eq[n])
                         ? lane_key[2*n] : lane_key[2*n+1];
      end
   end

   always_ff @(posedge clock) begin
      mid_ctl_ff <= mid_ctl_in;
      mid_key_ff <= mid_key_in;
   end

   // Final tree level and truth table lookup by presence mask.
   always_comb begin
      fin_lt  = mid_key_ff[0] < mid_key_ff[1];
      fin_eq  = mid_key_ff[0] == mid_key_ff[1];
      fin_ctl = merge_ctl(mid_ctl_ff[0], mid_ctl_ff[1], fin_lt, fin_eq);
      rsp_in.any_live      = fin_ctl.live;
      rsp_in.presence_mask = fin_ctl.mask;
      rsp_in.first_stream  = fin_ctl.first;
      rsp_in.keep_key      = fin_ctl.live && truth[fin_ctl.mask[7:6]][fin_ctl.mask[5:0]];
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // Word valid pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= in_valid;
         out_valid_ff <= mid_valid_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

>>> rtl/core/kway_head_min_select.sv
// Top level of the k-way head minimum select: registers, compare lanes and merge stages.
//
//   channel   direction  handshake            payload
//   command   in         start / busy         req_word (req_type)
//   result    out        rsp_valid strobe     rsp_word (rsp_type)
//   csr       in         csr_valid/csr_ready  csr_index, csr_data
//
// A command word is taken every cycle; busy never rises. Its result is registered in
// turn in the compare lanes, in the middle merge level and in the final merge with the
// truth table lookup. Synchronous reset clears the valid pipeline and restores the
// registers. The result strobe lasts one cycle and the receiver cannot hold it off.
module kway_head_min_select #(
   parameter int NUM_STREAMS = 8,
   parameter int KEY_BITS    = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  khms_pkg::req_type                 req_word,
   output logic                              rsp_valid,
   output khms_pkg::rsp_type                 rsp_word,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [khms_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [khms_pkg::KEY_W-1:0]        csr_data
);
   import khms_pkg::*;

   localparam logic [COUNT_W-1:0] USED_MAX = COUNT_W'(NUM_STREAMS);

   logic [COUNT_W-1:0]                   num_tables_ff;
   logic [TRUTH_WORDS-1:0][KEY_W-1:0]    truth_ff;
   logic [COUNT_W-1:0]                   used_count;
   logic                                 accept;
   logic                                 lane_valid_ff;
   logic [MAX_STREAMS-1:0][KEY_W-1:0]    keys;
   node_ctl_type [3:0]                   lane_ctl;
   logic [3:0][KEY_BITS-1:0]             lane_key;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_tables_ff <= 4'd8;
         truth_ff      <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NUM_TABLES: num_tables_ff <= csr_data[COUNT_W-1:0];
            CSR_TRUTH_0:    truth_ff[0]   <= csr_data;
            CSR_TRUTH_1:    truth_ff[1]   <= csr_data;
            CSR_TRUTH_2:    truth_ff[2]   <= csr_data;
            CSR_TRUTH_3:    truth_ff[3]   <= csr_data;
            default: ;
         endcase
      end
   end

   // Streams in use, saturated at the built stream count.
   assign used_count = (num_tables_ff > USED_MAX) ? USED_MAX : num_tables_ff;

   assign keys = {req_word.key_7, req_word.key_6, req_word.key_5, req_word.key_4,
                  req_word.key_3, req_word.key_2, req_word.key_1, req_word.key_0};

   // Four compare lanes, two streams each.
   for (genvar g = 0; g < 4; g++) begin : g_lane
      khms_lane_pair #(
         .KEY_BITS(KEY_BITS),
         .LANE    (g)
      ) u_lane (
         .clock     (clock),
         .valid_pair(req_word.head_valid[2*g+1:2*g]),
         .key_lo    (keys[2*g]),
         .key_hi    (keys[2*g+1]),
         .used_count(used_count),
         .node_ctl  (lane_ctl[g]),
         .node_key  (lane_key[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_valid_ff <= 1'b0;
      end else begin
         lane_valid_ff <= accept;
      end
   end

   // Merge of the lane minima.
   khms_merge #(
      .KEY_BITS(KEY_BITS)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .in_valid (lane_valid_ff),
      .lane_ctl (lane_ctl),
      .lane_key (lane_key),
      .truth    (truth_ff),
      .rsp_valid(rsp_valid),
      .rsp_word (rsp_word)
   );

   // An accepted word is followed by its result strobe.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##2 rsp_valid)
      else $error("result strobe missing after accepted word");

   // With no live stream every result field is zero.
   a_dead_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.any_live |->
         rsp_word.presence_mask == '0 && rsp_word.first_stream == '0 && !rsp_word.keep_key)
      else $error("nonzero fields without a live stream");

   // The first stream is a member of the presence mask.
   a_first_in_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.any_live |-> rsp_word.presence_mask[rsp_word.first_stream])
      else $error("first stream not in presence mask");

endmodule

>>> test/khms_result_checker.sv
// Result checker for the k-way head minimum select: predicts every result word and compares it.
module khms_result_checker
   import khms_pkg::*;
#(
   parameter int NUM_STREAMS = 8,
   parameter int KEY_BITS    = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  req_type              req_word,
   input  logic                 rsp_valid,
   input  rsp_type              rsp_word,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [KEY_W-1:0]     csr_data,
   output int                   mismatch_count,
   output int                   words_in_flight
);

   // Key bits above KEY_BITS take no part in the comparison.
   localparam logic [KEY_W-1:0] KEY_KEEP = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);

   // Shadow copy of the configuration registers.
   logic [COUNT_W-1:0] streams_in_use;
   logic [KEY_W-1:0]   truth_words [TRUTH_WORDS];

   // Result words predicted but not yet seen on the result port.
   rsp_type expected_words [$];

   // Works out the merge step: minimum over live streams, its mask, first index and keep bit.
   function automatic rsp_type predict_min(input req_type w);
      logic [KEY_W-1:0] keys [MAX_STREAMS];
      logic [KEY_W-1:0] best;
      logic [KEY_W-1:0] k;
      rsp_type          r;
      int               in_use;
      keys[0] = w.key_0;
      keys[1] = w.key_1;
      keys[2] = w.key_2;
      keys[3] = w.key_3;
      keys[4] = w.key_4;
      keys[5] = w.key_5;
      keys[6] = w.key_6;
      keys[7] = w.key_7;
      // A stream count above the number of streams saturates.
      in_use = (int'(streams_in_use) > NUM_STREAMS) ? NUM_STREAMS : int'(streams_in_use);
      r = '0;
      best = '0;
      for (int c = 0; c < NUM_STREAMS; c++) begin
         if (c < in_use && w.head_valid[c]) begin
            k = keys[c] & KEY_KEEP;
            if (!r.any_live || k < best) begin
               r.any_live = 1'b1;
               best = k;
               r.presence_mask = '0;
               r.presence_mask[c] = 1'b1;
               r.first_stream = STREAM_W'(c);
            end else if (k == best) begin
               r.presence_mask[c] = 1'b1;
            end
         end
      end
      // The truth table is looked up only when some stream is live.
      if (r.any_live) begin
         r.keep_key = truth_words[r.presence_mask[7:6]][r.presence_mask[5:0]];
      end
      return r;
   endfunction

   task automatic check_field(input string field, input logic [KEY_W-1:0] want,
                              input logic [KEY_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         mismatch_count++;
      end
   endtask

   // Track register writes, queue a prediction per accepted word, compare each result word.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         streams_in_use = COUNT_W'(MAX_STREAMS);
         for (int i = 0; i < TRUTH_WORDS; i++) begin
            truth_words[i] = '0;
         end
         expected_words.delete();
         mismatch_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NUM_TABLES: streams_in_use = csr_data[COUNT_W-1:0];
               CSR_TRUTH_0:    truth_words[0] = csr_data;
               CSR_TRUTH_1:    truth_words[1] = csr_data;
               CSR_TRUTH_2:    truth_words[2] = csr_data;
               CSR_TRUTH_3:    truth_words[3] = csr_data;
               default: ;
            endcase
         end
         if (start && !busy) begin
            expected_words.push_back(predict_min(req_word));
         end
         if (rsp_valid) begin
            if (expected_words.size() == 0) begin
               $error("result word arrived with none expected");
               mismatch_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("any_live", KEY_W'(want.any_live), KEY_W'(rsp_word.any_live));
               check_field("presence_mask", KEY_W'(want.presence_mask),
                           KEY_W'(rsp_word.presence_mask));
               check_field("first_stream", KEY_W'(want.first_stream),
                           KEY_W'(rsp_word.first_stream));
               check_field("keep_key", KEY_W'(want.keep_key), KEY_W'(rsp_word.keep_key));
            end
         end
      end
      words_in_flight = expected_words.size();
   end

endmodule

>>> test/kway_head_min_select_tb.sv
// Testbench top for the k-way head minimum select: clock, reset, stimulus and verdict.
module kway_head_min_select_tb;
   import khms_pkg::*;

   localparam int NUM_STREAMS   = 8;
   localparam int KEY_BITS      = 64;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_WORDS   = 64;
   localparam int PHASE_COUNT   = 9;

   typedef logic [KEY_W-1:0] key_set_type [MAX_STREAMS];

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_word;
   logic                 rsp_valid;
   rsp_type              rsp_word;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [KEY_W-1:0]     csr_data;
   int                   mismatch_count;
   int                   words_in_flight;
   int                   cycle_count = 0;
   bit                   idle_enabled;

   kway_head_min_select #(
      .NUM_STREAMS(NUM_STREAMS),
      .KEY_BITS   (KEY_BITS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_word (rsp_word),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   khms_result_checker #(
      .NUM_STREAMS(NUM_STREAMS),
      .KEY_BITS   (KEY_BITS)
   ) result_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_word       (rsp_word),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .words_in_flight(words_in_flight)
   );

   // Free-running clock with a period of four time units.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("kway_head_min_select: mismatch");
         $finish;
      end
   end

   function automatic req_type pack_word(input logic [MAX_STREAMS-1:0] valid,
                                         input key_set_type keys);
      req_type w;
      w.head_valid = valid;
      w.key_0 = keys[0];
      w.key_1 = keys[1];
      w.key_2 = keys[2];
      w.key_3 = keys[3];
      w.key_4 = keys[4];
      w.key_5 = keys[5];
      w.key_6 = keys[6];
      w.key_7 = keys[7];
      return w;
   endfunction

   // Random heads, often drawn near one base value so that ties and near misses are common.
   function automatic req_type random_word();
      key_set_type            keys;
      logic [KEY_W-1:0]       base;
      logic [MAX_STREAMS-1:0] valid;
      base = {$urandom, $urandom};
      for (int c = 0; c < MAX_STREAMS; c++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: keys[c] = base + KEY_W'($urandom_range(0, 2));
            4:          keys[c] = '0;
            5:          keys[c] = '1;
            6:          keys[c] = KEY_W'($urandom_range(0, 3));
            7:          keys[c] = base ^ {1'b1, {(KEY_W-1){1'b0}}};
            default:    keys[c] = {$urandom, $urandom};
         endcase
      end
      case ($urandom_range(0, 7))
         0:       valid = '0;
         1:       valid = '1;
         2:       valid = MAX_STREAMS'(1 << $urandom_range(0, MAX_STREAMS - 1));
         default: valid = MAX_STREAMS'($urandom_range(0, 255));
      endcase
      return pack_word(valid, keys);
   endfunction

   // Present one command word at the falling edge and hold it until it is taken.
   task automatic send_word(input req_type w);
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // One register write; the caller lowers csr_valid after the last write of a group.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [KEY_W-1:0] value);
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         csr_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop sending and let every outstanding result word come back, plus pipeline slack.
   task automatic wait_for_results();
      start <= 1'b0;
      while (words_in_flight != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write every register, sometimes also an index past the last register.
   task automatic configure(input logic [COUNT_W-1:0] streams, input key_set_type truth);
      logic [KEY_W-1:0] data;
      data = {$urandom, $urandom};
      data[COUNT_W-1:0] = streams;
      write_csr(CSR_NUM_TABLES, data);
      write_csr(CSR_TRUTH_0, truth[0]);
      write_csr(CSR_TRUTH_1, truth[1]);
      write_csr(CSR_TRUTH_2, truth[2]);
      write_csr(CSR_TRUTH_3, truth[3]);
      if ($urandom_range(0, 1) == 1) begin
         write_csr(CSR_TRUTH_3 + CSR_IDX_W'($urandom_range(1, 3)), {$urandom, $urandom});
      end
      csr_valid <= 1'b0;
   endtask

   // Hand-picked heads: no live stream, full ties, extremes, ordering and masked streams.
   task automatic run_directed();
      key_set_type keys;
      for (int c = 0; c < MAX_STREAMS; c++) keys[c] = {$urandom, $urandom};
      send_word(pack_word('0, keys));
      for (int c = 0; c < MAX_STREAMS; c++) keys[c] = '0;
      send_word(pack_word('1, keys));
      for (int c = 0; c < MAX_STREAMS; c++) keys[c] = '1;
      send_word(pack_word('1, keys));
      send_word(pack_word(8'b1000_0000, keys));
      for (int c = 0; c < MAX_STREAMS; c++) keys[c] = KEY_W'(c);
      send_word(pack_word('1, keys));
      send_word(pack_word(8'b0000_0001, keys));
      for (int c = 0; c < MAX_STREAMS; c++) keys[c] = KEY_W'(MAX_STREAMS - 1 - c);
      send_word(pack_word('1, keys));
      // Two streams tie on the minimum.
      for (int c = 0; c < MAX_STREAMS; c++) keys[c] = KEY_W'(100);
      keys[3] = KEY_W'(5);
      keys[6] = KEY_W'(5);
      send_word(pack_word('1, keys));
      // The top key bit must compare as unsigned.
      for (int c = 0; c < MAX_STREAMS; c++) keys[c] = {1'b1, {(KEY_W-1){1'b0}}};
      keys[6] = KEY_W'(1);
      send_word(pack_word('1, keys));
      for (int c = 0; c < MAX_STREAMS; c++) keys[c] = {1'b0, {(KEY_W-1){1'b1}}};
      keys[2] = {1'b1, {(KEY_W-1){1'b0}}};
      keys[5] = {1'b0, {(KEY_W-2){1'b1}}, 1'b0};
      send_word(pack_word('1, keys));
      // A smaller key on an invalid stream is ignored.
      for (int c = 0; c < MAX_STREAMS; c++) keys[c] = KEY_W'(9);
      keys[3] = '0;
      send_word(pack_word(8'b1111_0111, keys));
      // Each stream alone.
      for (int c = 0; c < MAX_STREAMS; c++) begin
         keys[c] = {$urandom, $urandom};
      end
      for (int c = 0; c < MAX_STREAMS; c++) begin
         send_word(pack_word(MAX_STREAMS'(1 << c), keys));
      end
   endtask

   // Main stimulus: reset defaults, directed words, then phases over several settings.
   initial begin
      key_set_type        truth;
      logic [COUNT_W-1:0] streams;
      reset        = 1'b1;
      start        = 1'b0;
      req_word     = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      idle_enabled = 1'b1;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values: all streams in use, nothing kept.
      repeat (20) send_word(random_word());
      wait_for_results();

      for (int i = 0; i < MAX_STREAMS; i++) truth[i] = {$urandom, $urandom};
      configure(COUNT_W'(MAX_STREAMS), truth);
      run_directed();
      wait_for_results();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:       streams = COUNT_W'(MAX_STREAMS);
            1:       streams = COUNT_W'(1);
            2:       streams = '0;
            3:       streams = '1;
            4:       streams = COUNT_W'(3);
            5:       streams = COUNT_W'(MAX_STREAMS + 1);
            6:       streams = COUNT_W'(5);
            7:       streams = COUNT_W'($urandom_range(0, 15));
            default: streams = COUNT_W'(MAX_STREAMS);
         endcase
         for (int i = 0; i < TRUTH_WORDS; i++) begin
            case (phase % 4)
               0:       truth[i] = {$urandom, $urandom};
               1:       truth[i] = '1;
               2:       truth[i] = '0;
               default: truth[i] = (i % 2 == 0) ? {(KEY_W/2){2'b10}} : {(KEY_W/2){2'b01}};
            endcase
         end
         // The last phase runs at full rate.
         if (phase == PHASE_COUNT - 1) idle_enabled = 1'b0;
         configure(streams, truth);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            send_word(random_word());
            if (phase == 4 && n == PHASE_WORDS / 2) wait_for_results();
         end
         wait_for_results();
      end

      if (mismatch_count == 0) begin
         $display("kway_head_min_select: match");
      end else begin
         $display("kway_head_min_select: mismatch");
      end
      $finish;
   end

endmodule
